// ===== hw/rtl/vertex_rotate_project_assert.svh =====
// ----------------------------------------------------------------------------
// Vertex rotate/project assertion macros
// Shared concurrent assertion forms for the vertex pipeline.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_ASSERT_SVH

// Plain property checked on every rising clock edge outside reset.
`define VRP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define VRP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VRP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex rotate/project package
// Transaction types, register indexes, constants and the quarter-wave sine
// generator used to build the trig table at elaboration.
// ----------------------------------------------------------------------------
package vrp_pkg;

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic signed [15:0] vert_z;
    } vrp_in_t;

    typedef struct packed {
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic signed [15:0] rot_z;
        logic signed [11:0] screen_x;
        logic signed [11:0] screen_y;
    } vrp_out_t;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ANGLE_X     = 2'd0,
        REG_ANGLE_Y     = 2'd1,
        REG_ANGLE_Z     = 2'd2,
        REG_ORTHO_SCALE = 2'd3
    } vrp_reg_e;

    localparam logic [15:0] SCALE_RESET = 16'd12800;
    localparam int          CENTRE_COL  = 220;
    localparam int          CENTRE_ROW  = 110;
    localparam int          NUM_STAGES  = 9;

    localparam logic [63:0] TRIG_ONE = 64'd16384;
    localparam logic [63:0] POLY_A   = 64'd102944;
    localparam logic [63:0] POLY_B   = 64'd42048;
    localparam logic [63:0] POLY_C   = 64'd4640;

    // Q1.14 magnitude of sine at position pos of a quarter wave of 2^qbits steps.
    function automatic logic [14:0] qsine_entry(input int unsigned pos,
                                                input int unsigned qbits);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] f;
        logic [63:0] s;
        z  = 64'(pos) << (16 - qbits);
        z2 = (z * z) >> 16;
        t  = POLY_B - ((z2 * POLY_C) >> 16);
        u  = POLY_A - ((z2 * t) >> 16);
        f  = (z * u) >> 16;
        s  = (f + 64'd2) >> 2;
        if (s > TRIG_ONE)
        begin
            s = TRIG_ONE;
        end
        return s[14:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v < -32'sd32768)
        begin
            return 16'sh8000;
        end
        else if (v > 32'sd32767)
        begin
            return 16'sh7fff;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [11:0] sat12(input logic signed [31:0] v);
        if (v < -32'sd2048)
        begin
            return 12'sh800;
        end
        else if (v > 32'sd2047)
        begin
            return 12'sh7ff;
        end
        return v[11:0];
    endfunction

endpackage

// ===== hw/rtl/vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// Vertex rotate/project
// Rotates each vertex about X, then Y, then Z and forms an orthographic
// screen position around column 220, row 110.
// Input channel in_valid/in_stall/in_data carries one vertex per transaction;
// output channel out_valid/out_stall/out_data returns one result per vertex,
// in order. The user must write angles and scale through cfg_we/cfg_index/
// cfg_wdata only while the pipe is empty; the block does not enforce this.
// They apply to the next vertex accepted. Results pass through nine
// register stages (input capture, three multiply/round pairs with the
// clamp in the last round, scale, screen). Throughput is one vertex per
// cycle while the receiver does not stall; each stage after capture holds
// one multiplier rank or one add step. When the receiver stalls, stages
// fill up behind the output register, empty stages still accept, and
// in_stall rises only once the capture stage is occupied and cannot move.
// Reset empties the pipe, sets the angles to zero and the scale to 50.0.
// ----------------------------------------------------------------------------
`include "vertex_rotate_project_assert.svh"

module vertex_rotate_project
    import vrp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 13,
    parameter int SINE_TABLE_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  vrp_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output vrp_out_t               out_data
);

    localparam int STB     = SINE_TABLE_BITS;
    localparam int QUARTER = 2 ** (STB - 2);
    localparam int SHIFT   = COORD_FRAC_BITS + 8;
    localparam logic [STB-1:0]     QTR_IDX  = {2'b01, {(STB-2){1'b0}}};
    localparam logic [STB-2:0]     QTR_POS  = {1'b1, {(STB-2){1'b0}}};
    localparam logic signed [33:0] TRUNC_BIAS = (34'sd1 <<< SHIFT) - 34'sd1;

    // Configuration registers
    logic [15:0] angle_x_reg;
    logic [15:0] angle_y_reg;
    logic [15:0] angle_z_reg;
    logic [15:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            scale_reg   <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_X:     angle_x_reg <= cfg_wdata;
                REG_ANGLE_Y:     angle_y_reg <= cfg_wdata;
                REG_ANGLE_Z:     angle_z_reg <= cfg_wdata;
                REG_ORTHO_SCALE: scale_reg   <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Quarter-wave sine table, one extra entry so the mirrored quarter reaches 1.0.
    logic [14:0] qtab [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_qtab
        assign qtab[g] = qsine_entry(g, STB - 2);
    end

    // Lookups in order: sin x, cos x, sin y, cos y, sin z, cos z.
    logic [STB-1:0]     tidx [6];
    logic signed [15:0] tval [6];
    logic signed [15:0] trig_reg [6];

    always_comb
    begin
        tidx[0] = angle_x_reg[15 -: STB];
        tidx[1] = angle_x_reg[15 -: STB] + QTR_IDX;
        tidx[2] = angle_y_reg[15 -: STB];
        tidx[3] = angle_y_reg[15 -: STB] + QTR_IDX;
        tidx[4] = angle_z_reg[15 -: STB];
        tidx[5] = angle_z_reg[15 -: STB] + QTR_IDX;
    end

    always_comb
    begin
        logic [1:0]     quad;
        logic [STB-2:0] pos;
        logic [14:0]    mag;
        for (int k = 0; k < 6; k++)
        begin
            quad = tidx[k][STB-1 -: 2];
            pos  = {1'b0, tidx[k][STB-3:0]};
            if (quad[0])
            begin
                pos = QTR_POS - pos;
            end
            mag = qtab[pos];
            if (quad[1])
            begin
                tval[k] = -signed'({1'b0, mag});
            end
            else
            begin
                tval[k] = signed'({1'b0, mag});
            end
        end
    end

    // Trig values are registered and follow the angle registers in the cycle
    // after; the capture stage covers that delay before the first multiply uses them.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
        begin
            trig_reg[k] <= tval[k];
        end
    end

    // Pipeline control: a stage may load when it is empty or the one after moves.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Stage 0: capture
    vrp_in_t in_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            in_reg <= in_data;
        end
    end

    // Stage 1: X rotation products
    logic signed [31:0] s1_ycx_next, s1_zsx_next, s1_ysx_next, s1_zcx_next;
    logic signed [31:0] s1_ycx_reg, s1_zsx_reg, s1_ysx_reg, s1_zcx_reg;
    logic signed [15:0] s1_px_reg;

    always_comb
    begin
        s1_ycx_next = 32'(in_reg.vert_y) * 32'(trig_reg[1]);
        s1_zsx_next = 32'(in_reg.vert_z) * 32'(trig_reg[0]);
        s1_ysx_next = 32'(in_reg.vert_y) * 32'(trig_reg[0]);
        s1_zcx_next = 32'(in_reg.vert_z) * 32'(trig_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_ycx_reg <= s1_ycx_next;
            s1_zsx_reg <= s1_zsx_next;
            s1_ysx_reg <= s1_ysx_next;
            s1_zcx_reg <= s1_zcx_next;
            s1_px_reg  <= in_reg.vert_x;
        end
    end

    // Stage 2: round X rotation; the floor shift is a plain bit select.
    logic signed [32:0] s2_ysum, s2_zsum;
    logic signed [18:0] s2_y1_reg, s2_z1_reg;
    logic signed [15:0] s2_px_reg;

    always_comb
    begin
        s2_ysum = 33'(s1_ycx_reg) - 33'(s1_zsx_reg) + 33'sd8192;
        s2_zsum = 33'(s1_ysx_reg) + 33'(s1_zcx_reg) + 33'sd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_y1_reg <= s2_ysum[32:14];
            s2_z1_reg <= s2_zsum[32:14];
            s2_px_reg <= s1_px_reg;
        end
    end

    // Stage 3: Y rotation products
    logic signed [34:0] s3_xcy_reg, s3_zsy_reg, s3_zcy_reg, s3_xsy_reg;
    logic signed [18:0] s3_y1_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_xcy_reg <= 35'(s2_px_reg) * 35'(trig_reg[3]);
            s3_zsy_reg <= 35'(s2_z1_reg) * 35'(trig_reg[2]);
            s3_zcy_reg <= 35'(s2_z1_reg) * 35'(trig_reg[3]);
            s3_xsy_reg <= 35'(s2_px_reg) * 35'(trig_reg[2]);
            s3_y1_reg  <= s2_y1_reg;
        end
    end

    // Stage 4: round Y rotation
    logic signed [35:0] s4_xsum, s4_zsum;
    logic signed [21:0] s4_x2_reg, s4_z2_reg;
    logic signed [18:0] s4_y1_reg;

    always_comb
    begin
        s4_xsum = 36'(s3_xcy_reg) + 36'(s3_zsy_reg) + 36'sd8192;
        s4_zsum = 36'(s3_zcy_reg) - 36'(s3_xsy_reg) + 36'sd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_x2_reg <= s4_xsum[35:14];
            s4_z2_reg <= s4_zsum[35:14];
            s4_y1_reg <= s3_y1_reg;
        end
    end

    // Stage 5: Z rotation products
    logic signed [37:0] s5_xcz_reg, s5_ysz_reg, s5_xsz_reg, s5_ycz_reg;
    logic signed [21:0] s5_z2_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_xcz_reg <= 38'(s4_x2_reg) * 38'(trig_reg[5]);
            s5_ysz_reg <= 38'(s4_y1_reg) * 38'(trig_reg[4]);
            s5_xsz_reg <= 38'(s4_x2_reg) * 38'(trig_reg[4]);
            s5_ycz_reg <= 38'(s4_y1_reg) * 38'(trig_reg[5]);
            s5_z2_reg  <= s4_z2_reg;
        end
    end

    // Stage 6: round Z rotation and saturate all three coordinates.
    logic signed [38:0] s6_xsum, s6_ysum;
    logic signed [24:0] s6_rx, s6_ry;
    logic signed [15:0] s6_rx_reg, s6_ry_reg, s6_rz_reg;

    always_comb
    begin
        s6_xsum = 39'(s5_xcz_reg) - 39'(s5_ysz_reg) + 39'sd8192;
        s6_ysum = 39'(s5_xsz_reg) + 39'(s5_ycz_reg) + 39'sd8192;
        s6_rx   = s6_xsum[38:14];
        s6_ry   = s6_ysum[38:14];
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_rx_reg <= sat16(32'(s6_rx));
            s6_ry_reg <= sat16(32'(s6_ry));
            s6_rz_reg <= sat16(32'(s5_z2_reg));
        end
    end

    // Stage 7: scale products
    logic signed [33:0] s7_mx_reg, s7_my_reg;
    logic signed [15:0] s7_rx_reg, s7_ry_reg, s7_rz_reg;
    logic signed [16:0] scale_s;

    assign scale_s = signed'({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_mx_reg <= 34'(s6_rx_reg) * 34'(scale_s);
            s7_my_reg <= 34'(s6_ry_reg) * 34'(scale_s);
            s7_rx_reg <= s6_rx_reg;
            s7_ry_reg <= s6_ry_reg;
            s7_rz_reg <= s6_rz_reg;
        end
    end

    // Stage 8: divide toward zero by biasing negatives, then offset and clamp.
    logic signed [33:0] s8_xadj, s8_yadj, s8_qx, s8_qy, s8_col, s8_row;
    vrp_out_t           out_next;
    vrp_out_t           out_reg;

    always_comb
    begin
        s8_xadj = s7_mx_reg + (s7_mx_reg[33] ? TRUNC_BIAS : 34'sd0);
        s8_yadj = s7_my_reg + (s7_my_reg[33] ? TRUNC_BIAS : 34'sd0);
        s8_qx   = s8_xadj >>> SHIFT;
        s8_qy   = s8_yadj >>> SHIFT;
        s8_col  = 34'(CENTRE_COL) + s8_qx;
        s8_row  = 34'(CENTRE_ROW) - s8_qy;
        out_next.rot_x    = s7_rx_reg;
        out_next.rot_y    = s7_ry_reg;
        out_next.rot_z    = s7_rz_reg;
        out_next.screen_x = sat12(32'(s8_col));
        out_next.screen_y = sat12(32'(s8_row));
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    // Checks
    `VRP_ASSERT_IMPL(a_stall_needs_capture, clk, rst_n,
        in_stall, valid_reg[0], "input stalled while the capture stage is empty")
    `VRP_ASSERT_IMPL(a_full_and_blocked, clk, rst_n,
        (&valid_reg) && out_stall, in_stall, "full pipe blocked but input accepted")
    `VRP_ASSERT_IMPL(a_occupancy, clk, rst_n,
        $past(rst_n), $countones(valid_reg) == $past($countones(valid_reg))
            + $past(int'(in_valid && !in_stall)) - $past(int'(out_valid && !out_stall)),
        "pipe occupancy does not match accepted and delivered transactions")

endmodule
